// ===== src/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int LIN_W      = COL_W + ROW_W + 1;
    localparam int COPY_LAST  = (ROWS - 1) * COLUMNS - 1;
    localparam int FILL_LAST  = CELL_COUNT - 1;
    localparam int TAB_STOP   = 8;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] BLANK_ATTR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec_put;
        logic exec_clear;
        logic exec_read;
        logic copy_step;
        logic fill_step;
        logic load_out;
    } tcw_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  scroll_needed;
        logic  copy_last;
        logic  fill_last;
        logic  out_blocked;
    } tcw_status_t;

endpackage

// ===== src/tcw_ctrl.sv =====
module tcw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (status.kind)
                    KIND_PUT:   state_next = status.scroll_needed ? ST_COPY : ST_DONE;
                    KIND_CLEAR: state_next = ST_FILL;
                    KIND_READ:  state_next = ST_RDWAIT;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_COPY: begin
                if (status.copy_last) state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_FILL;
            ST_FILL: begin
                if (status.fill_last) state_next = ST_DONE;
            end
            ST_RDWAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (!status.out_blocked) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_EXEC: begin
                cmd.exec_put   = (status.kind == KIND_PUT);
                cmd.exec_clear = (status.kind == KIND_CLEAR);
                cmd.exec_read  = (status.kind == KIND_READ);
            end
            ST_COPY:  cmd.copy_step = 1'b1;
            ST_FILL:  cmd.fill_step = 1'b1;
            ST_DONE:  cmd.load_out  = !status.out_blocked;
            default: begin
            end
        endcase
    end

endmodule

// ===== src/tcw_datapath.sv =====
module tcw_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcw_pkg::tcw_cmd_t    cmd,
    output tcw_pkg::tcw_status_t status,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    input  logic [1:0]           s_kind,
    input  logic [7:0]           s_char_code,
    input  logic [3:0]           s_back_color,
    input  logic [3:0]           s_fore_color,
    input  logic [10:0]          s_read_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [10:0]          m_cursor_pos,
    output logic [15:0]          m_cell_word
);
    import tcw_pkg::*;

    logic [15:0] mem [CELL_COUNT];
    logic [15:0] rd_data_reg;

    logic [7:0]  blank_attr_reg;
    kind_t       kind_reg;
    logic [7:0]  code_reg;
    logic [7:0]  attr_reg;
    logic [10:0] ridx_reg;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;

    logic              m_valid_reg;
    logic [10:0]       loc_reg;
    logic [15:0]       word_reg;

    logic [7:0]        col_w;
    logic [ROW_W:0]    row_w;
    logic              wr_cell;
    logic              scroll;
    logic [LIN_W-1:0]  lin;
    logic              ridx_ok;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    assign lin     = LIN_W'(row_reg) * LIN_W'(COLUMNS) + LIN_W'(col_reg);
    assign ridx_ok = ({2'b00, ridx_reg} < 13'(CELL_COUNT));

    // cursor movement for a put request
    always_comb begin
        col_w   = {1'b0, col_reg};
        row_w   = {1'b0, row_reg};
        wr_cell = 1'b0;
        case (code_reg)
            CH_BS: begin
                if (col_reg != '0) col_w = col_w - 8'd1;
            end
            CH_TAB: col_w = (col_w + 8'(TAB_STOP)) & ~8'(TAB_STOP - 1);
            CH_CR:  col_w = 8'd0;
            CH_LF: begin
                col_w = 8'd0;
                row_w = row_w + (ROW_W + 1)'(1);
            end
            default: begin
                if (!code_reg[7] && code_reg >= CH_SPACE) begin
                    wr_cell = 1'b1;
                    col_w   = col_w + 8'd1;
                end
            end
        endcase
        if (col_w >= 8'(COLUMNS)) begin
            col_w = 8'd0;
            row_w = row_w + (ROW_W + 1)'(1);
        end
    end

    assign scroll = (row_w >= (ROW_W + 1)'(ROWS));

    assign status.kind          = kind_reg;
    assign status.scroll_needed = scroll;
    assign status.copy_last     = (sweep_reg == ADDR_W'(COPY_LAST));
    assign status.fill_last     = (sweep_reg == ADDR_W'(FILL_LAST));
    assign status.out_blocked   = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_attr_reg <= BLANK_ATTR_RESET;
        end else if (cfg_valid) begin
            blank_attr_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= kind_t'(s_kind);
            code_reg <= s_char_code;
            attr_reg <= {s_back_color, s_fore_color};
            ridx_reg <= s_read_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.exec_put) begin
            col_reg <= col_w[COL_W-1:0];
            row_reg <= scroll ? ROW_W'(ROWS - 1) : row_w[ROW_W-1:0];
        end else if (cmd.exec_clear) begin
            col_reg <= '0;
            row_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= cmd.copy_step;
            if (cmd.exec_put || cmd.exec_clear) begin
                sweep_reg <= '0;
            end else if (cmd.copy_step || cmd.fill_step) begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.copy_step) pend_addr_reg <= sweep_reg;
    end

    // copy writes land in the cycle after their reads
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = {blank_attr_reg, CH_SPACE};
        if (cmd.exec_put && wr_cell) begin
            mem_we    = 1'b1;
            mem_waddr = lin[ADDR_W-1:0];
            mem_wdata = {attr_reg, code_reg};
        end else if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = rd_data_reg;
        end else if (cmd.fill_step) begin
            mem_we    = 1'b1;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(ridx_reg);
        if (cmd.exec_read) begin
            mem_re = ridx_ok;
        end else if (cmd.copy_step) begin
            mem_re    = 1'b1;
            mem_raddr = sweep_reg + ADDR_W'(COLUMNS);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            loc_reg  <= lin[10:0];
            word_reg <= (kind_reg == KIND_READ && ridx_ok) ? rd_data_reg : 16'd0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = loc_reg;
    assign m_cell_word  = word_reg;

endmodule

// ===== src/text_console_cell_writer.sv =====
// channel   dir  handshake                 payload
// cfg       in   cfg_valid / cfg_ready     cfg_data (blank attribute)
// s_        in   s_valid / s_ready         kind, char_code, back/fore color, read_index
// m_        out  m_valid / m_ready         cursor_pos, cell_word
//
// put and nop pass idle, exec, done; a read adds a wait (one registered memory read)
// a scrolling put adds a copy sweep of the upper rows, a drain and a bottom-row fill;
// a clear adds a fill of every cell: one screen memory write port, one cell per cycle
// aresetn clears cursor, controller and output valid; the screen memory is not cleared
// a waiting result sits in the output register while the next request is taken;
// that request then holds in its last cycle until the result is taken
module text_console_cell_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_char_code,
    input  logic [3:0]  s_back_color,
    input  logic [3:0]  s_fore_color,
    input  logic [10:0] s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_cursor_pos,
    output logic [15:0] m_cell_word
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .s_kind       (s_kind),
        .s_char_code  (s_char_code),
        .s_back_color (s_back_color),
        .s_fore_color (s_fore_color),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_cell_word  (m_cell_word)
    );

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_SET_BLANK,
        STEP_SETTLE
    } step_t;

    typedef struct {
        step_t       step;
        kind_t       kind;
        logic [7:0]  code;
        logic [3:0]  back;
        logic [3:0]  fore;
        logic [10:0] cell_index;
        logic [7:0]  attr;
        int          gap;
    } console_request_t;

    typedef struct packed {
        logic [10:0] loc;
        logic [15:0] word;
    } console_reply_t;

    localparam int LONG_STALL   = 3000;
    localparam int FINAL_CYCLES = 20;
    localparam int PHASE_ITEMS  = 175;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [7:0]  s_char_code = '0;
    logic [3:0]  s_back_color = '0;
    logic [3:0]  s_fore_color = '0;
    logic [10:0] s_read_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_cursor_pos;
    logic [15:0] m_cell_word;

    text_console_cell_writer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_char_code  (s_char_code),
        .s_back_color (s_back_color),
        .s_fore_color (s_fore_color),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_cell_word  (m_cell_word)
    );

    console_request_t requests_queued[$];
    console_reply_t   replies_due[$];

    // predicted console state
    logic [15:0]      screen_model [CELL_COUNT];
    logic [COL_W-1:0] col_model = '0;
    logic [ROW_W-1:0] row_model = '0;
    logic [7:0]       blank_attr_model = BLANK_ATTR_RESET;

    logic sender_lazy = 1'b1;
    int   gap_left = 0;
    int   stall_left = 0;
    logic long_stall_done = 1'b0;
    int   results_seen = 0;
    int   mismatches = 0;
    logic s_took = 1'b0;
    logic cfg_took = 1'b0;
    console_request_t offer;

    initial forever #5 aclk = ~aclk;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #100_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [15:0] blank_cell();
        return {blank_attr_model, CH_SPACE};
    endfunction

    task automatic console_step(input console_request_t rq);
        int c;
        int r;
        int i;
        logic [15:0] word;
        c = col_model;
        r = row_model;
        word = '0;
        case (rq.kind)
            KIND_PUT: begin
                if (rq.code == CH_BS) begin
                    if (c != 0) c--;
                end else if (rq.code == CH_TAB) begin
                    c = (c + TAB_STOP) & ~(TAB_STOP - 1);
                end else if (rq.code == CH_CR) begin
                    c = 0;
                end else if (rq.code == CH_LF) begin
                    c = 0;
                    r++;
                end else if (rq.code >= CH_SPACE && !rq.code[7]) begin
                    screen_model[r * COLUMNS + c] = {rq.back, rq.fore, rq.code};
                    c++;
                end
                if (c >= COLUMNS) begin
                    c = 0;
                    r++;
                end
                // scroll up one row, blank the bottom row
                if (r >= ROWS) begin
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_model[i] = blank_cell();
                    r = ROWS - 1;
                end
            end
            KIND_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++)
                    screen_model[i] = blank_cell();
                c = 0;
                r = 0;
            end
            KIND_READ: begin
                if (rq.cell_index < CELL_COUNT) word = screen_model[rq.cell_index];
            end
            default: ;
        endcase
        col_model = COL_W'(c);
        row_model = ROW_W'(r);
        replies_due.push_back({11'(r * COLUMNS + c), word});
    endtask

    function automatic int draw_gap();
        int r;
        if (!sender_lazy) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic queue_request(input kind_t kind, input logic [7:0] code,
                                 input logic [3:0] back, input logic [3:0] fore,
                                 input logic [10:0] cell_index);
        console_request_t rq;
        rq.step = STEP_REQUEST;
        rq.kind = kind;
        rq.code = code;
        rq.back = back;
        rq.fore = fore;
        rq.cell_index = cell_index;
        rq.attr = '0;
        rq.gap = draw_gap();
        requests_queued.push_back(rq);
    endtask

    task automatic queue_control(input step_t step, input logic [7:0] attr);
        console_request_t rq;
        rq.step = step;
        rq.kind = KIND_NOP;
        rq.code = '0;
        rq.back = '0;
        rq.fore = '0;
        rq.cell_index = '0;
        rq.attr = attr;
        rq.gap = 0;
        requests_queued.push_back(rq);
    endtask

    task automatic queue_printable(input logic [3:0] back, input logic [3:0] fore);
        queue_request(KIND_PUT, 8'($urandom_range(32, 127)), back, fore, 11'($urandom));
    endtask

    task automatic queue_code(input logic [7:0] code);
        queue_request(KIND_PUT, code, 4'($urandom), 4'($urandom), 11'($urandom));
    endtask

    // text runs with line breaks, tabs and edits, plus reads, clears and junk
    task automatic random_phase(input int count);
        int made;
        int r;
        int n;
        logic [3:0] b;
        logic [3:0] f;
        made = 0;
        queue_request(KIND_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom), 11'($urandom));
        while (made < count) begin
            r = $urandom_range(0, 99);
            b = 4'($urandom);
            f = 4'($urandom);
            if (r < 45) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 100)
                                                 : $urandom_range(1, 8);
                repeat (n) queue_printable(b, f);
                made += n;
            end else if (r < 60) begin
                queue_code(CH_LF);
                made++;
            end else if (r < 63) begin
                // walk down to the bottom and keep scrolling
                n = $urandom_range(8, 30);
                repeat (n) begin
                    queue_printable(b, f);
                    queue_code(CH_LF);
                end
                made += 2 * n;
            end else if (r < 67) begin
                queue_code(CH_CR);
                made++;
            end else if (r < 72) begin
                queue_code(CH_TAB);
                made++;
            end else if (r < 76) begin
                queue_code(CH_BS);
                made++;
            end else if (r < 80) begin
                queue_code($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(128, 255)));
                made++;
            end else if (r < 95) begin
                queue_request(KIND_READ, 8'($urandom), b, f,
                              ($urandom_range(0, 9) == 0)
                                  ? 11'($urandom_range(CELL_COUNT, 2047))
                                  : 11'($urandom_range(0, CELL_COUNT - 1)));
                made++;
            end else if (r < 98) begin
                queue_request(KIND_NOP, 8'($urandom), b, f, 11'($urandom));
                made++;
            end else begin
                queue_request(KIND_CLEAR, 8'($urandom), b, f, 11'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        // cells are unknown until the first clear
        queue_request(KIND_CLEAR, 8'h00, 4'h0, 4'h0, 11'h000);
        queue_request(KIND_PUT, 8'h41, 4'h0, 4'h0, 11'h7FF);
        queue_request(KIND_PUT, 8'h7F, 4'hF, 4'hF, 11'h000);
        queue_request(KIND_PUT, CH_SPACE, 4'h5, 4'hA, 11'h555);
        queue_request(KIND_READ, 8'hFF, 4'hF, 4'hF, 11'd0);
        queue_request(KIND_READ, 8'h00, 4'h0, 4'h0, 11'd2);
        queue_request(KIND_PUT, CH_BS, 4'h1, 4'h2, 11'h000);
        queue_request(KIND_PUT, CH_CR, 4'h3, 4'h4, 11'h000);
        // backspace at column zero stays put
        queue_request(KIND_PUT, CH_BS, 4'h5, 4'h6, 11'h000);
        queue_request(KIND_PUT, CH_TAB, 4'h7, 4'h8, 11'h000);
        queue_request(KIND_PUT, 8'h5A, 4'h9, 4'h6, 11'h2AA);
        queue_request(KIND_PUT, CH_LF, 4'hA, 4'hB, 11'h000);
        // control codes and high codes are dropped
        queue_request(KIND_PUT, 8'h00, 4'hC, 4'hD, 11'h000);
        queue_request(KIND_PUT, 8'h1F, 4'hE, 4'hF, 11'h000);
        queue_request(KIND_PUT, 8'h80, 4'hF, 4'hF, 11'h000);
        queue_request(KIND_PUT, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        queue_request(KIND_READ, 8'h00, 4'h0, 4'h0, 11'd8);
        queue_request(KIND_READ, 8'h00, 4'h0, 4'h0, 11'(CELL_COUNT - 1));
        queue_request(KIND_READ, 8'h00, 4'h0, 4'h0, 11'(CELL_COUNT));
        queue_request(KIND_READ, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        queue_request(KIND_NOP, 8'hA5, 4'h3, 4'hC, 11'h2AA);

        queue_control(STEP_SET_BLANK, 8'h00);
        random_phase(PHASE_ITEMS);
        queue_control(STEP_SET_BLANK, 8'hFF);
        random_phase(PHASE_ITEMS / 2);
        queue_control(STEP_SETTLE, 8'h00);
        random_phase(PHASE_ITEMS / 2);
        queue_control(STEP_SET_BLANK, 8'($urandom));
        sender_lazy = 1'b0;
        random_phase(PHASE_ITEMS);
        sender_lazy = 1'b1;
        queue_control(STEP_SET_BLANK, 8'h5A);
        random_phase(PHASE_ITEMS);
        queue_control(STEP_SET_BLANK, 8'($urandom));
        random_phase(PHASE_ITEMS);

        while (requests_queued.size() != 0 || s_valid || cfg_valid) @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (FINAL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, replies_due.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    always @(negedge aclk) begin : drive
        logic s_hold;
        logic cfg_hold;
        if (aresetn) begin
            s_hold = s_valid;
            cfg_hold = cfg_valid;
            if (s_valid && s_took) begin
                console_step(offer);
                s_hold = 1'b0;
            end
            if (cfg_valid && cfg_took) begin
                blank_attr_model = offer.attr;
                cfg_hold = 1'b0;
            end
            if (!s_hold && !cfg_hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (requests_queued.size() != 0 &&
                             !(requests_queued[0].step != STEP_REQUEST &&
                               replies_due.size() != 0)) begin
                    // register writes and pauses wait for every reply
                    offer = requests_queued.pop_front();
                    gap_left = offer.gap;
                    case (offer.step)
                        STEP_REQUEST: begin
                            s_hold = 1'b1;
                            s_kind <= offer.kind;
                            s_char_code <= offer.code;
                            s_back_color <= offer.back;
                            s_fore_color <= offer.fore;
                            s_read_index <= offer.cell_index;
                        end
                        STEP_SET_BLANK: begin
                            cfg_hold = 1'b1;
                            cfg_data <= offer.attr;
                        end
                        default: ;
                    endcase
                end
            end
            s_valid <= s_hold;
            cfg_valid <= cfg_hold;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!long_stall_done && results_seen >= 150) begin
                // long hold so the block backs up into its input
                long_stall_done = 1'b1;
                stall_left = LONG_STALL - 1;
                m_ready <= 1'b0;
            end else if (results_seen >= 500 && results_seen < 600) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 30) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void note_mismatch(input string what, input logic [15:0] want,
                                          input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s expected 0x%0h got 0x%0h", results_seen, what, want, got);
    endfunction

    always @(posedge aclk) begin : check
        console_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                note_mismatch("unrequested result, cursor_pos", '0, 16'(m_cursor_pos));
            end else begin
                want = replies_due.pop_front();
                if (m_cursor_pos !== want.loc)
                    note_mismatch("cursor_pos", 16'(want.loc), 16'(m_cursor_pos));
                if (m_cell_word !== want.word)
                    note_mismatch("cell_word", want.word, m_cell_word);
            end
        end
    end

endmodule

// ===== filelist.f =====
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_cell_writer.sv
sim/testbench.sv
